// ===== rtl/core/baro_pressure_temp_compensation_defines.svh =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_defines.svh
// Assertion macros shared by the compensation core.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define BPTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BPTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// Widths, constants and register indexes of the barometric compensation core.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // beat fields
  localparam int RawW   = 24;
  localparam int CalW   = 16;
  localparam int PressW = 23;
  localparam int TempW  = 19;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS       = 3'd0,
    REG_OFFSET     = 3'd1,
    REG_SENS_TC    = 3'd2,
    REG_OFFSET_TC  = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_TC    = 3'd5,
    REG_PRESENT    = 3'd6
  } cfg_idx_t;

  // internal widths
  localparam int DtW    = 25;  // raw temp minus reference, signed
  localparam int ProdW  = 42;  // dT times a 16-bit coefficient, signed
  localparam int OffW   = 36;  // offset term, signed
  localparam int SensW  = 35;  // sensitivity term, signed
  localparam int SensLoW = 18; // low slice of SENS for the split multiply
  localparam int FullW  = 60;  // raw pressure times SENS, signed
  localparam int DiffW  = 40;  // scaled product minus offset
  localparam int PFullW = 25;  // pressure before clamping

  // constants of the formula
  localparam logic signed [TempW-1:0]  TempBase = 19'sd2000;
  localparam logic signed [PFullW-1:0] PMax     = 25'sd4194303;
  localparam logic signed [PFullW-1:0] PMin     = -25'sd4194304;
  localparam logic signed [TempW-1:0]  TMax     = 19'sd140000;
  localparam logic signed [TempW-1:0]  TMin     = -19'sd140000;

endpackage

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// First-order barometric compensation: one raw pressure / temperature pair
// in, one compensated pressure (0.01 mbar) and temperature (0.01 C) out.
// Six calibration words and a sensor-present flag come in over a plain
// write port. The datapath is a six-stage pipeline (reference subtract,
// three coefficient multiplies, term sums, split pressure multiply,
// partial-product merge, offset subtract with clamp into the output
// register); it takes one beat per clock unless the output stalls. Any
// output stall freezes the whole pipeline, so in_ready follows out_ready
// whenever the output register is full. With the present flag clear both
// results read zero.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [bptc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bptc_pkg::CfgDataW-1:0]       cfg_data,
  // input beat
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bptc_pkg::RawW-1:0]           raw_pressure,
  input  logic [bptc_pkg::RawW-1:0]           raw_temperature,
  // output beat
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bptc_pkg::PressW-1:0]  pressure_centi_mbar,
  output logic signed [bptc_pkg::TempW-1:0]   temperature_centi_c
);

  import bptc_pkg::*;

  // calibration registers
  logic [CalW-1:0] c_sens;
  logic [CalW-1:0] c_offset;
  logic [CalW-1:0] c_sens_tc;
  logic [CalW-1:0] c_offset_tc;
  logic [CalW-1:0] c_ref_temp;
  logic [CalW-1:0] c_temp_tc;
  logic            present;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_sens      <= '0;
      c_offset    <= '0;
      c_sens_tc   <= '0;
      c_offset_tc <= '0;
      c_ref_temp  <= '0;
      c_temp_tc   <= '0;
      present     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENS:      c_sens      <= cfg_data;
        REG_OFFSET:    c_offset    <= cfg_data;
        REG_SENS_TC:   c_sens_tc   <= cfg_data;
        REG_OFFSET_TC: c_offset_tc <= cfg_data;
        REG_REF_TEMP:  c_ref_temp  <= cfg_data;
        REG_TEMP_TC:   c_temp_tc   <= cfg_data;
        REG_PRESENT:   present     <= cfg_data[0];
        default:       ;  // index beyond the list: dropped
      endcase
    end
  end

  // global pipeline advance: moves whenever the output slot frees up
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // stage valids
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  // stage 1: dT = raw temp - reference * 256
  logic [RawW-1:0]        s1_raw_p;
  logic signed [DtW-1:0]  s1_dt;
  logic signed [DtW-1:0]  dt_next;

  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, c_ref_temp, 8'h00});

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_raw_p <= raw_pressure;
      s1_dt    <= dt_next;
    end
  end

  // stage 2: the three coefficient products
  logic [RawW-1:0]          s2_raw_p;
  logic signed [ProdW-1:0]  s2_t_prod;
  logic signed [ProdW-1:0]  s2_off_prod;
  logic signed [ProdW-1:0]  s2_sens_prod;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_raw_p     <= s1_raw_p;
      s2_t_prod    <= s1_dt * $signed({1'b0, c_temp_tc});
      s2_off_prod  <= s1_dt * $signed({1'b0, c_offset_tc});
      s2_sens_prod <= s1_dt * $signed({1'b0, c_sens_tc});
    end
  end

  // stage 3: TEMP, OFF and SENS terms
  logic [RawW-1:0]          s3_raw_p;
  logic signed [TempW-1:0]  s3_temp;
  logic signed [OffW-1:0]   s3_off;
  logic signed [SensW-1:0]  s3_sens;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_raw_p <= s2_raw_p;
      s3_temp  <= TempBase + $signed(s2_t_prod[ProdW-1:23]);
      s3_off   <= $signed({3'b000, c_offset, 17'h0}) + $signed(s2_off_prod[ProdW-1:6]);
      s3_sens  <= $signed({3'b000, c_sens, 16'h0}) + $signed(s2_sens_prod[ProdW-1:7]);
    end
  end

  // stage 4: raw pressure * SENS as two partial products
  logic [ProdW-1:0]         s4_pp_lo;
  logic signed [ProdW-1:0]  s4_pp_hi;
  logic signed [TempW-1:0]  s4_temp;
  logic signed [OffW-1:0]   s4_off;

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_pp_lo <= ProdW'(s3_raw_p) * ProdW'(s3_sens[SensLoW-1:0]);
      s4_pp_hi <= $signed({1'b0, s3_raw_p}) * $signed(s3_sens[SensW-1:SensLoW]);
      s4_temp  <= s3_temp;
      s4_off   <= s3_off;
    end
  end

  // stage 5: merge partial products
  logic signed [FullW-1:0]  s5_full;
  logic signed [TempW-1:0]  s5_temp;
  logic signed [OffW-1:0]   s5_off;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_full <= $signed({s4_pp_hi, {SensLoW{1'b0}}}) + $signed({18'h0, s4_pp_lo});
      s5_temp <= s4_temp;
      s5_off  <= s4_off;
    end
  end

  // stage 6: P = ((full >> 21) - OFF) >> 15, clamp, present mask
  logic signed [DiffW-1:0]   diff;
  logic signed [PFullW-1:0]  p_full;
  logic signed [PressW-1:0]  p_clamped;
  logic signed [PressW-1:0]  pressure_next;
  logic signed [TempW-1:0]   temperature_next;

  always_comb begin
    diff   = DiffW'($signed(s5_full[FullW-1:21])) - DiffW'(s5_off);
    p_full = diff[DiffW-1:15];
    priority if (p_full > PMax) begin
      p_clamped = PressW'(PMax);
    end else if (p_full < PMin) begin
      p_clamped = PressW'(PMin);
    end else begin
      p_clamped = p_full[PressW-1:0];
    end
    pressure_next    = present ? p_clamped : '0;
    temperature_next = present ? s5_temp : '0;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pressure_centi_mbar <= pressure_next;
      temperature_centi_c <= temperature_next;
    end
  end

  // checks
  `BPTC_ASSERT_NEXT(a_in_enters, in_valid && in_ready, s1_valid, "accepted beat not in stage 1")
  `BPTC_ASSERT_NEXT(a_out_follows, advance, out_valid == $past(s5_valid), "output valid lost or invented")
  `BPTC_ASSERT_NOW(a_temp_range, out_valid, (temperature_centi_c <= TMax) && (temperature_centi_c >= TMin), "temperature out of range")

endmodule

// ===== dv/baro_comp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_comp_checker
// Watches the calibration port and both beat channels of the compensation
// core. It keeps its own copy of the calibration words and works out the
// compensated reading for every accepted sample pair. Output beats are
// compared in order, field by field, against those readings.
// ----------------------------------------------------------------------------
module baro_comp_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bptc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bptc_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [bptc_pkg::RawW-1:0]           raw_pressure,
  input  logic [bptc_pkg::RawW-1:0]           raw_temperature,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [bptc_pkg::PressW-1:0]  pressure_centi_mbar,
  input  logic signed [bptc_pkg::TempW-1:0]   temperature_centi_c,
  output int                                  fail_count,
  output int                                  pending
);

  import bptc_pkg::*;

  localparam longint PressHi = 4194303;
  localparam longint PressLo = -4194304;
  localparam longint TempHi  = 140000;
  localparam longint TempLo  = -140000;

  typedef struct packed {
    logic signed [PressW-1:0] pressure;
    logic signed [TempW-1:0]  temperature;
  } reading_t;

  // calibration copy, indexed by register name
  logic [CalW-1:0] cal_word [6];
  logic            cal_present;

  reading_t expected_readings [$];

  // first-order compensation; >>> on signed longint floors like the sensor math
  function automatic reading_t compensate(logic [RawW-1:0] rp, logic [RawW-1:0] rt);
    longint signed d1, d2, c1, c2, c3, c4, c5, c6;
    longint signed dt, t, off, sens, p;
    reading_t r;
    r = '0;
    if (!cal_present) return r;
    d1 = rp;
    d2 = rt;
    c1 = cal_word[REG_SENS];
    c2 = cal_word[REG_OFFSET];
    c3 = cal_word[REG_SENS_TC];
    c4 = cal_word[REG_OFFSET_TC];
    c5 = cal_word[REG_REF_TEMP];
    c6 = cal_word[REG_TEMP_TC];
    dt   = d2 - c5 * 256;
    t    = 2000 + ((dt * c6) >>> 23);
    off  = c2 * 131072 + ((c4 * dt) >>> 6);
    sens = c1 * 65536 + ((c3 * dt) >>> 7);
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    // saturate into the output ranges
    if (p > PressHi) p = PressHi;
    if (p < PressLo) p = PressLo;
    if (t > TempHi) t = TempHi;
    if (t < TempLo) t = TempLo;
    r.pressure    = p[PressW-1:0];
    r.temperature = t[TempW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    int errs;
    reading_t want;
    errs = 0;
    if (rst) begin
      expected_readings.delete();
      cal_present <= 1'b0;
      for (int k = 0; k < 6; k++) cal_word[k] <= '0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      // input beat: predict the reading with the current calibration
      if (in_valid && in_ready)
        expected_readings.push_back(compensate(raw_pressure, raw_temperature));

      // output beat: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got pressure %0d temperature %0d",
                   $time, pressure_centi_mbar, temperature_centi_c);
          errs++;
        end else begin
          want = expected_readings.pop_front();
          if (pressure_centi_mbar !== want.pressure) begin
            $display("%0t: pressure mismatch, expected %0d, got %0d",
                     $time, want.pressure, pressure_centi_mbar);
            errs++;
          end
          if (temperature_centi_c !== want.temperature) begin
            $display("%0t: temperature mismatch, expected %0d, got %0d",
                     $time, want.temperature, temperature_centi_c);
            errs++;
          end
        end
      end

      // calibration writes; indexes past the list are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_SENS, REG_OFFSET, REG_SENS_TC, REG_OFFSET_TC, REG_REF_TEMP, REG_TEMP_TC:
            cal_word[cfg_index] <= cfg_data;
          REG_PRESENT: cal_present <= cfg_data[0];
          default: ;
        endcase
      end

      fail_count <= fail_count + errs;
      pending <= expected_readings.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the barometric compensation core. Calibration
// sets (typical, all-ones, all-zero, sensor absent, random) are loaded while
// the pipeline is empty; directed corner pairs come first, then random pairs
// under changing sender and receiver idle mixes, long output stalls and a
// mid-phase sender pause. Checking lives in baro_comp_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bptc_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 12;
  localparam int NumPhases     = 9;
  localparam int PairsPerPhase = 220;
  localparam int PauseAt       = 110;
  localparam int HoldEvery     = 700;
  localparam int HoldCycles    = 64;

  localparam logic [CfgIdxW-1:0] RegBeyond = 3'd7;
  localparam logic [RawW-1:0]    RawMax    = '1;

  // typical factory calibration words
  localparam logic [CalW-1:0] TypSens    = 16'd46372;
  localparam logic [CalW-1:0] TypOffset  = 16'd43981;
  localparam logic [CalW-1:0] TypSensTc  = 16'd29059;
  localparam logic [CalW-1:0] TypOffTc   = 16'd27842;
  localparam logic [CalW-1:0] TypRefTemp = 16'd31553;
  localparam logic [CalW-1:0] TypTempTc  = 16'd28165;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic [RawW-1:0]     raw_pressure = '0;
  logic [RawW-1:0]     raw_temperature = '0;
  logic                out_ready = 1'b0;
  wire                 in_ready;
  wire                 out_valid;
  wire signed [PressW-1:0] pressure_centi_mbar;
  wire signed [TempW-1:0]  temperature_centi_c;

  int fail_count;
  int pending;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int pairs_sent   = 0;
  int results_seen = 0;
  int cal_sets     = 0;
  int long_stalls  = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  logic [CalW-1:0] cur_ref = '0;

  baro_pressure_temp_compensation dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .raw_pressure        (raw_pressure),
    .raw_temperature     (raw_temperature),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .pressure_centi_mbar (pressure_centi_mbar),
    .temperature_centi_c (temperature_centi_c)
  );

  baro_comp_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .raw_pressure        (raw_pressure),
    .raw_temperature     (raw_temperature),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .pressure_centi_mbar (pressure_centi_mbar),
    .temperature_centi_c (temperature_centi_c),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random backpressure plus a long stall every HoldEvery beats
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (out_valid && out_ready && ((results_seen + 1) % HoldEvery) == 0) begin
        out_ready <= 1'b0;
        hold_left <= HoldCycles;
        long_stalls <= long_stalls + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // one register write; cfg_we is dropped by the caller after a burst
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // load a full calibration set, plus a stray write past the register list
  task automatic apply_cal(input logic [CalW-1:0] c1, c2, c3, c4, c5, c6,
                           input logic [CfgDataW-1:0] present_word);
    write_reg(REG_SENS, c1);
    write_reg(REG_OFFSET, c2);
    write_reg(REG_SENS_TC, c3);
    write_reg(REG_OFFSET_TC, c4);
    write_reg(REG_REF_TEMP, c5);
    write_reg(REG_TEMP_TC, c6);
    write_reg(REG_PRESENT, present_word);
    write_reg(RegBeyond, 16'($urandom()));
    cfg_we <= 1'b0;
    cur_ref = c5;
    cal_sets++;
  endtask

  // offer one sample pair, with random idle cycles ahead of it
  task automatic send_pair(input logic [RawW-1:0] rp, input logic [RawW-1:0] rt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_pressure <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
  endtask

  // stop offering and let every outstanding reading come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // mostly full-range counts, some near the reference temperature, some extremes
  task automatic random_pair(output logic [RawW-1:0] rp, output logic [RawW-1:0] rt);
    int kind;
    int delta;
    longint signed t;
    kind = $urandom_range(9);
    rp = RawW'($urandom());
    rt = RawW'($urandom());
    if (kind >= 5 && kind <= 7) begin
      delta = int'($urandom_range(131072)) - 65536;
      t = longint'({cur_ref, 8'h00}) + delta;
      if (t < 0) t = 0;
      else if (t > RawMax) t = RawMax;
      rt = t[RawW-1:0];
    end else if (kind == 8) begin
      rp = ($urandom_range(1) != 0) ? RawMax : '0;
    end else if (kind == 9) begin
      rp = ($urandom_range(1) != 0) ? RawMax : '0;
      rt = ($urandom_range(1) != 0) ? RawMax : '0;
    end
  endtask

  initial begin : stimulus
    logic [RawW-1:0] rp, rt;
    int mode;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: typical calibration, count extremes and dT around zero
    apply_cal(TypSens, TypOffset, TypSensTc, TypOffTc, TypRefTemp, TypTempTc, 16'h0001);
    send_pair('0, '0);
    send_pair(RawMax, RawMax);
    send_pair('0, RawMax);
    send_pair(RawMax, '0);
    send_pair(24'd6465444, 24'd8077636);
    send_pair(24'd6465444, {cur_ref, 8'h00});
    send_pair(24'd6465444, {cur_ref, 8'h00} - 24'd1);
    send_pair(24'd6465444, {cur_ref, 8'h00} + 24'd1);

    // directed: all-ones calibration, present written with junk upper bits
    wait_drained();
    apply_cal('1, '1, '1, '1, '1, '1, 16'hFFFF);
    send_pair('0, '0);
    send_pair(RawMax, RawMax);
    send_pair('0, RawMax);
    send_pair(RawMax, '0);

    // directed: all-zero calibration
    wait_drained();
    apply_cal('0, '0, '0, '0, '0, '0, 16'h0001);
    send_pair(RawMax, RawMax);
    send_pair('0, '0);
    send_pair(RawMax, '0);

    // directed: sensor absent forces zero readings
    wait_drained();
    apply_cal(TypSens, TypOffset, TypSensTc, TypOffTc, TypRefTemp, TypTempTc, 16'hFFFE);
    send_pair(RawMax, RawMax);
    send_pair(24'd123456, 24'd654321);
    send_pair('0, '0);

    // random phases: idle mix changes every three calibration sets
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      case (ph)
        0: apply_cal(TypSens, TypOffset, TypSensTc, TypOffTc, TypRefTemp, TypTempTc,
                     16'h0001);
        1: apply_cal('1, '1, '1, '1, '1, '1, 16'h0001);
        2: apply_cal('0, '0, '0, '0, '0, '0, 16'h0001);
        3: apply_cal(TypSens, TypOffset, TypSensTc, TypOffTc, TypRefTemp, TypTempTc,
                     16'h0000);
        default: apply_cal(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()), 16'($urandom()),
                           {15'($urandom()), 1'b1});
      endcase
      mode = ph / 3;
      tx_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 62 : 0;
      rx_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 27 : 0;
      for (int i = 0; i < PairsPerPhase; i++) begin
        // sender pause until the pipeline is empty
        if (i == PauseAt) wait_drained();
        random_pair(rp, rt);
        send_pair(rp, rt);
      end
    end

    wait_drained();
    $display("Summary: %0d sample pairs over %0d calibration sets, %0d readings compared",
             pairs_sent, cal_sets, results_seen);
    $display("Summary: idle mixes 27/62, 62/27 and none; %0d long output stalls",
             long_stalls);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
